FILE: design/mcpf_pkg.sv
// shared types, codes and lookup functions for the motor command packet framer
// no dependencies
package mcpf_pkg;

  localparam int unsigned OpW      = 4;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned WordW    = 32;
  localparam int unsigned IdxW     = 5;
  localparam int unsigned PayBytes = 17;
  localparam int unsigned PayW     = PayBytes * ByteW;
  localparam int unsigned SumW     = 7;

  // command kinds
  localparam logic [OpW-1:0] OP_FWD1      = 4'd0;
  localparam logic [OpW-1:0] OP_BACK1     = 4'd1;
  localparam logic [OpW-1:0] OP_FWD2      = 4'd2;
  localparam logic [OpW-1:0] OP_BACK2     = 4'd3;
  localparam logic [OpW-1:0] OP_DRIVE1    = 4'd4;
  localparam logic [OpW-1:0] OP_DRIVE2    = 4'd5;
  localparam logic [OpW-1:0] OP_PID1      = 4'd6;
  localparam logic [OpW-1:0] OP_PID2      = 4'd7;
  localparam logic [OpW-1:0] OP_SPD1      = 4'd8;
  localparam logic [OpW-1:0] OP_SPD2      = 4'd9;
  localparam logic [OpW-1:0] OP_SPD12     = 4'd10;
  localparam logic [OpW-1:0] OP_SPDDIST12 = 4'd11;

  // command codes sent on the wire
  localparam logic [ByteW-1:0] CMD_FWD1      = 8'd0;
  localparam logic [ByteW-1:0] CMD_BACK1     = 8'd1;
  localparam logic [ByteW-1:0] CMD_FWD2      = 8'd4;
  localparam logic [ByteW-1:0] CMD_BACK2     = 8'd5;
  localparam logic [ByteW-1:0] CMD_DRIVE1    = 8'd6;
  localparam logic [ByteW-1:0] CMD_DRIVE2    = 8'd7;
  localparam logic [ByteW-1:0] CMD_PID1      = 8'd28;
  localparam logic [ByteW-1:0] CMD_PID2      = 8'd29;
  localparam logic [ByteW-1:0] CMD_SPD1      = 8'd35;
  localparam logic [ByteW-1:0] CMD_SPD2      = 8'd36;
  localparam logic [ByteW-1:0] CMD_SPD12     = 8'd37;
  localparam logic [ByteW-1:0] CMD_SPDDIST12 = 8'd43;

  localparam logic [ByteW-1:0] DIST_FLAG = 8'd1;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic emit;
  } mcpf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic op_ok;
    logic out_free;
    logic at_last;
  } mcpf_stat_t;

  function automatic logic op_valid(input logic [OpW-1:0] op);
    op_valid = (op <= OP_SPDDIST12);
  endfunction

  function automatic logic [ByteW-1:0] cmd_code(input logic [OpW-1:0] op);
    logic [ByteW-1:0] c;
    c = CMD_FWD1;
    unique case (op)
      OP_FWD1:      c = CMD_FWD1;
      OP_BACK1:     c = CMD_BACK1;
      OP_FWD2:      c = CMD_FWD2;
      OP_BACK2:     c = CMD_BACK2;
      OP_DRIVE1:    c = CMD_DRIVE1;
      OP_DRIVE2:    c = CMD_DRIVE2;
      OP_PID1:      c = CMD_PID1;
      OP_PID2:      c = CMD_PID2;
      OP_SPD1:      c = CMD_SPD1;
      OP_SPD2:      c = CMD_SPD2;
      OP_SPD12:     c = CMD_SPD12;
      OP_SPDDIST12: c = CMD_SPDDIST12;
      default:      c = CMD_FWD1;
    endcase
    cmd_code = c;
  endfunction

  // payload byte count per command
  function automatic logic [IdxW-1:0] pay_len(input logic [OpW-1:0] op);
    logic [IdxW-1:0] n;
    n = 5'd1;
    unique case (op)
      OP_PID1, OP_PID2:   n = 5'd16;
      OP_SPD1, OP_SPD2:   n = 5'd4;
      OP_SPD12:           n = 5'd8;
      OP_SPDDIST12:       n = 5'd17;
      default:            n = 5'd1;
    endcase
    pay_len = n;
  endfunction

endpackage

FILE: design/mcpf_ctrl.sv
// controller state machine of the packet framer
// depends on mcpf_pkg
module mcpf_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  mcpf_pkg::mcpf_stat_t stat,
  output mcpf_pkg::mcpf_cmd_t  cmd
);
  import mcpf_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SEND = 2'b10
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd.load = (state == ST_IDLE) && in_valid && stat.op_ok;
    cmd.emit = (state == ST_SEND) && stat.out_free;
    in_stall = (state != ST_IDLE);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (cmd.load) state_next = ST_SEND;
      ST_SEND: if (cmd.emit && stat.at_last) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

endmodule

FILE: design/mcpf_dp.sv
// datapath of the packet framer: payload shifter, byte index, checksum, output register
// depends on mcpf_pkg
module mcpf_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [mcpf_pkg::OpW-1:0]            op,
  input  logic [mcpf_pkg::ByteW-1:0]          address,
  input  logic [mcpf_pkg::WordW-1:0]          word_a,
  input  logic [mcpf_pkg::WordW-1:0]          word_b,
  input  logic [mcpf_pkg::WordW-1:0]          word_c,
  input  logic [mcpf_pkg::WordW-1:0]          word_d,
  input  mcpf_pkg::mcpf_cmd_t                 cmd,
  output mcpf_pkg::mcpf_stat_t                stat,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [mcpf_pkg::ByteW-1:0]          packet_byte,
  output logic                                last
);
  import mcpf_pkg::*;

  logic [ByteW-1:0] addr_q;
  logic [ByteW-1:0] code_q;
  logic [PayW-1:0]  pay;
  logic [PayW-1:0]  pay_init;
  logic [IdxW-1:0]  idx;
  logic [IdxW-1:0]  last_idx;
  logic [SumW-1:0]  sum;
  logic [ByteW-1:0] cur_byte;
  logic             cur_last;

  // payload laid out most significant byte first
  always_comb begin
    pay_init = '0;
    unique case (op)
      OP_PID1, OP_PID2:
        pay_init = {word_a, word_b, word_c, word_d, {ByteW{1'b0}}};
      OP_SPD1, OP_SPD2:
        pay_init = {word_a, {(PayW-WordW){1'b0}}};
      OP_SPD12:
        pay_init = {word_a, word_b, {(PayW-2*WordW){1'b0}}};
      OP_SPDDIST12:
        pay_init = {word_a, word_c, word_b, word_d, DIST_FLAG};
      default:
        pay_init = {word_a[ByteW-1:0], {(PayW-ByteW){1'b0}}};
    endcase
  end

  always_comb begin
    cur_last = (idx == last_idx);
    priority if (idx == 5'd0)  cur_byte = addr_q;
    else if (idx == 5'd1)      cur_byte = code_q;
    else if (cur_last)         cur_byte = {1'b0, sum};
    else                       cur_byte = pay[PayW-1 -: ByteW];
  end

  always_comb begin
    stat.op_ok    = op_valid(op);
    stat.out_free = !out_valid || !out_stall;
    stat.at_last  = cur_last;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr_q   <= address;
      code_q   <= cmd_code(op);
      pay      <= pay_init;
      idx      <= '0;
      last_idx <= pay_len(op) + 5'd2;
      sum      <= '0;
    end else if (cmd.emit) begin
      idx <= idx + 5'd1;
      sum <= sum + cur_byte[SumW-1:0];
      if (idx >= 5'd2) pay <= {pay[PayW-ByteW-1:0], {ByteW{1'b0}}};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      packet_byte <= cur_byte;
      last        <= cur_last;
    end
  end

endmodule

FILE: design/motor_command_packet_framer_core.sv
// top level of the motor command packet framer
// depends on mcpf_pkg, mcpf_ctrl and mcpf_dp
//
// takes one motor command beat and sends its serial packet out one byte per beat:
// device address, command code, payload (one low byte for the open-loop commands,
// 32-bit words most significant byte first otherwise, plus a trailing flag byte of
// one for the speed-with-distance command) and a checksum byte, the sum of all
// earlier bytes masked to 7 bits, which carries last. packets are 4, 7, 11, 19 or
// 20 bytes long; a command kind above 11 is taken and dropped and gives no packet.
// one byte leaves per cycle while out_stall is low; the command is taken while
// the block is idle, before its first byte goes out, and in_stall is held from
// the cycle after a command is taken until the checksum byte has gone into the
// output register, so the next command may be taken while that byte still waits
// downstream. the byte index counter walks the payload shifter one byte per cycle
// while the output register is free to take a byte.
module motor_command_packet_framer_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [mcpf_pkg::OpW-1:0]   op,
  input  logic [mcpf_pkg::ByteW-1:0] address,
  input  logic [mcpf_pkg::WordW-1:0] word_a,
  input  logic [mcpf_pkg::WordW-1:0] word_b,
  input  logic [mcpf_pkg::WordW-1:0] word_c,
  input  logic [mcpf_pkg::WordW-1:0] word_d,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [mcpf_pkg::ByteW-1:0] packet_byte,
  output logic                       last
);
  import mcpf_pkg::*;

  // command and status between controller and datapath
  mcpf_cmd_t  cmd;
  mcpf_stat_t stat;

  // sequences the bytes of one packet
  mcpf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // holds the command, builds each byte and the checksum, drives the output beat
  mcpf_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .op          (op),
    .address     (address),
    .word_a      (word_a),
    .word_b      (word_b),
    .word_c      (word_c),
    .word_d      (word_d),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .packet_byte (packet_byte),
    .last        (last)
  );

endmodule
